// ===== rtl/core/sset_pkg.sv =====
// ----------------------------------------------------------------------------
// sset_pkg: shared definitions for the sorted set block
// Key width, result packing and default capacity.
// ----------------------------------------------------------------------------
package sset_pkg;

   localparam int KEY_W        = 16;
   localparam int CNT_OUT_W    = 8;
   localparam int RSP_W        = 16;
   localparam int CAPACITY_DEF = 128;

   typedef logic [KEY_W-1:0] key_type;

endpackage

// ===== rtl/core/sorted_set_insert_if_absent.sv =====
// Sequence: a binary search with one RAM read per probe, then a final check of
//   the slot found, then each larger entry is moved up one slot by a read and a
//   write, and the key is stored last; reads and writes use separate RAM ports.
// Throughput: one key at a time; the next key is taken once the result is queued.
// Reset: count cleared at once; key storage is left as is, no clearing pass.
// ----------------------------------------------------------------------------
// sorted_set_insert_if_absent: sorted key set with insert-if-absent
// Binary search over stored keys with a shared comparator, then an ordered
// insert by shifting larger keys up one slot at a time.
// ----------------------------------------------------------------------------
module sorted_set_insert_if_absent #(
   parameter int CAPACITY = sset_pkg::CAPACITY_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [sset_pkg::KEY_W-1:0] req_tdata,   // [15:0] key
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [sset_pkg::RSP_W-1:0] rsp_tdata    // [0] inserted, [1] duplicate,
                                                   // [2] full_res, [10:3] entry_count
);

   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);
   localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

   typedef enum logic [2:0] {
      ST_IDLE, ST_SRCH, ST_PROBE, ST_CHK, ST_SH_RD, ST_SH_WR, ST_RESP
   } state_type;

   state_type         state_ff, state_in;
   sset_pkg::key_type key_ff, key_in;
   logic [CW-1:0]     cnt_ff, cnt_in;
   logic [CW-1:0]     lo_ff, lo_in;
   logic [CW-1:0]     hi_ff, hi_in;
   logic [AW-1:0]     mid_ff, mid_in;
   logic [CW-1:0]     idx_ff, idx_in;
   logic              ins_ff, ins_in;
   logic              dup_ff, dup_in;
   logic              full_ff, full_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [sset_pkg::RSP_W-1:0] rsp_data_ff, rsp_data_in;

   logic              wr_en, rd_en;
   logic [AW-1:0]     wr_addr, rd_addr;
   sset_pkg::key_type wr_data, rd_data;
   logic [CW:0]       mid_sum;
   logic              key_lt, key_eq;

   sset_ram #(.DEPTH(CAPACITY), .AW(AW)) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   // shared comparator
   assign key_lt  = rd_data < key_ff;
   assign key_eq  = rd_data == key_ff;
   assign mid_sum = ({1'b0, lo_ff} + {1'b0, hi_ff}) >> 1;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      state_in     = state_ff;
      key_in       = key_ff;
      cnt_in       = cnt_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      mid_in       = mid_ff;
      idx_in       = idx_ff;
      ins_in       = ins_ff;
      dup_in       = dup_ff;
      full_in      = full_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      wr_en        = 1'b0;
      wr_addr      = idx_ff[AW-1:0];
      wr_data      = rd_data;
      rd_en        = 1'b0;
      rd_addr      = lo_ff[AW-1:0];

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               key_in   = req_tdata;
               lo_in    = '0;
               hi_in    = cnt_ff;
               state_in = ST_SRCH;
            end
         end
         ST_SRCH: begin
            if (lo_ff < hi_ff) begin
               mid_in   = mid_sum[AW-1:0];
               rd_en    = 1'b1;
               rd_addr  = mid_sum[AW-1:0];
               state_in = ST_PROBE;
            end else begin
               rd_en    = (lo_ff < cnt_ff);
               state_in = ST_CHK;
            end
         end
         ST_PROBE: begin
            if (key_lt) begin
               lo_in = CW'(mid_ff) + CW'(1);
            end else begin
               hi_in = CW'(mid_ff);
            end
            state_in = ST_SRCH;
         end
         ST_CHK: begin
            ins_in  = 1'b0;
            dup_in  = 1'b0;
            full_in = 1'b0;
            if ((lo_ff < cnt_ff) && key_eq) begin
               dup_in   = 1'b1;
               state_in = ST_RESP;
            end else if (cnt_ff >= CAP_C) begin
               full_in  = 1'b1;
               state_in = ST_RESP;
            end else begin
               idx_in   = cnt_ff;
               state_in = ST_SH_RD;
            end
         end
         ST_SH_RD: begin
            if (idx_ff > lo_ff) begin
               rd_en    = 1'b1;
               rd_addr  = AW'(idx_ff - CW'(1));
               state_in = ST_SH_WR;
            end else begin
               wr_en    = 1'b1;
               wr_addr  = lo_ff[AW-1:0];
               wr_data  = key_ff;
               cnt_in   = cnt_ff + CW'(1);
               ins_in   = 1'b1;
               state_in = ST_RESP;
            end
         end
         ST_SH_WR: begin
            wr_en    = 1'b1;
            idx_in   = idx_ff - CW'(1);
            state_in = ST_SH_RD;
         end
         ST_RESP: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {5'b0, sset_pkg::CNT_OUT_W'(cnt_ff), full_ff, dup_ff, ins_ff};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      key_ff      <= key_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      mid_ff      <= mid_in;
      idx_ff      <= idx_in;
      ins_ff      <= ins_in;
      dup_ff      <= dup_in;
      full_ff     <= full_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

// ===== rtl/core/sset_ram.sv =====
// ----------------------------------------------------------------------------
// sset_ram: key storage
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module sset_ram #(
   parameter int DEPTH = sset_pkg::CAPACITY_DEF,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  sset_pkg::key_type wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output sset_pkg::key_type rd_data
);

   sset_pkg::key_type mem [DEPTH];
   sset_pkg::key_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== bench/tb_sorted_set_insert_if_absent.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sorted_set_insert_if_absent: self-checking bench for the sorted key set
// Streams keys into the block in random bursts while the result side stalls
// on its own pattern. A scoreboard keeps its own sorted copy of the set,
// predicts inserted / duplicate / full and the count for every accepted key,
// and checks each result beat in order. Directed keys cover the extremes and
// ordered inserts; random keys fill the set, then hammer it while full.
// ----------------------------------------------------------------------------
module tb_sorted_set_insert_if_absent;

   localparam int SET_CAP      = sset_pkg::CAPACITY_DEF;
   localparam int RANDOM_ITEMS = 1650;
   localparam int TAIL_CYCLES  = 400;
   localparam logic [15:0] RX_PATTERN = 16'b1011_0111_0010_1101;

   typedef struct packed {
      logic       inserted;
      logic       duplicate;
      logic       full_res;
      logic [7:0] entry_count;
   } outcome_type;

   class sorted_set_tracker;
      sset_pkg::key_type keys [SET_CAP];
      int          count;
      outcome_type pending [$];
      int          errors;
      int          n_ins;
      int          n_dup;
      int          n_full;
      int          n_checked;

      function new();
         count     = 0;
         errors    = 0;
         n_ins     = 0;
         n_dup     = 0;
         n_full    = 0;
         n_checked = 0;
      endfunction

      function sset_pkg::key_type pick_stored();
         if (count == 0) return sset_pkg::key_type'($urandom);
         return keys[$urandom_range(0, count - 1)];
      endfunction

      // accepted key: update the shadow set and queue the expected outcome
      function void note_key(sset_pkg::key_type k);
         int          pos;
         int          i;
         bit          hit;
         outcome_type o;
         pos = 0;
         while (pos < count && keys[pos] < k) pos++;
         hit = (pos < count) && (keys[pos] == k);
         o = '0;
         if (hit) begin
            o.duplicate = 1'b1;
            n_dup++;
         end else if (count >= SET_CAP) begin
            o.full_res = 1'b1;
            n_full++;
         end else begin
            for (i = count; i > pos; i--) keys[i] = keys[i - 1];
            keys[pos] = k;
            count++;
            o.inserted = 1'b1;
            n_ins++;
         end
         o.entry_count = count[7:0];
         pending.push_back(o);
      endfunction

      function void compare_field(string name, int exp_val, int act_val);
         if (exp_val != act_val) begin
            errors++;
            $display("%0t ns: %s mismatch, expected %0d actual %0d",
                     $time, name, exp_val, act_val);
         end
      endfunction

      function void check_beat(logic [sset_pkg::RSP_W-1:0] d);
         outcome_type e;
         if (pending.size() == 0) begin
            errors++;
            $display("%0t ns: result beat with nothing expected, expected none actual %h",
                     $time, d);
            return;
         end
         e = pending.pop_front();
         n_checked++;
         compare_field("inserted", int'(e.inserted), int'(d[0]));
         compare_field("duplicate", int'(e.duplicate), int'(d[1]));
         compare_field("full_res", int'(e.full_res), int'(d[2]));
         compare_field("entry_count", int'(e.entry_count), int'(d[10:3]));
         compare_field("pad bits", 0, int'(d[sset_pkg::RSP_W-1:11]));
      endfunction
   endclass

   logic                           clock      = 1'b0;
   logic                           reset      = 1'b1;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic [sset_pkg::KEY_W-1:0]     req_tdata  = '0;   // [15:0] key
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   logic [sset_pkg::RSP_W-1:0]     rsp_tdata;         // [0] inserted, [1] duplicate,
                                                      // [2] full_res, [10:3] entry_count

   sorted_set_tracker tracker = new();
   int burst_left = 4;
   int keys_sent  = 0;
   int rx_cycle   = 0;
   int rx_mode    = 0;

   sorted_set_insert_if_absent #(
      .CAPACITY (SET_CAP)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // result side: check accepted beats, stall by mode
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) tracker.check_beat(rsp_tdata);
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rx_cycle <= rx_cycle + 1;
         if (rx_cycle % 256 == 255) rx_mode <= $urandom_range(0, 3);
         case (rx_mode)
            0:       rsp_tready <= 1'b1;
            1:       rsp_tready <= RX_PATTERN[rx_cycle % 16];
            2:       rsp_tready <= 1'($urandom_range(0, 1));
            default: rsp_tready <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   task automatic send_key(input sset_pkg::key_type k);
      int gap;
      req_tvalid <= 1'b1;
      req_tdata  <= k;
      do @(posedge clock); while (!req_tready);
      tracker.note_key(k);
      keys_sent++;
      burst_left--;
      if (burst_left <= 0) begin
         burst_left = ($urandom_range(0, 7) == 0) ? 48 : $urandom_range(1, 12);
         gap = $urandom_range(0, 14);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (tracker.pending.size() != 0) @(posedge clock);
   endtask

   initial begin
      sset_pkg::key_type directed [$];
      sset_pkg::key_type k;
      int                rnd_sent;
      directed = '{16'h8000, 16'h0000, 16'hFFFF, 16'h8000, 16'h0000, 16'hFFFF,
                   16'h7FFF, 16'h0001, 16'hFFFE, 16'h5555, 16'hAAAA, 16'h00FF,
                   16'hFF00, 16'h7FFF, 16'h8001, 16'h0002, 16'h5555, 16'hFFFE};
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[i]) send_key(directed[i]);
      drain_results();

      // fill: mostly new keys, some repeats and neighbors of stored keys
      rnd_sent = 0;
      while (tracker.count < SET_CAP && rnd_sent < RANDOM_ITEMS) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: k = sset_pkg::key_type'($urandom);
            6, 7:             k = tracker.pick_stored();
            8:                k = tracker.pick_stored() + 16'd1;
            default:          k = sset_pkg::key_type'($urandom_range(0, 63));
         endcase
         send_key(k);
         rnd_sent++;
      end
      drain_results();

      // full set: present keys come back as duplicates, absent ones are refused
      while (rnd_sent < RANDOM_ITEMS) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3: k = tracker.pick_stored();
            4, 5, 6:    k = sset_pkg::key_type'($urandom);
            7:          k = tracker.pick_stored() + 16'd1;
            8:          k = tracker.pick_stored() - 16'd1;
            default: begin
               k = 16'h0001 << $urandom_range(0, 15);
               if ($urandom_range(0, 1)) k = ~k;
            end
         endcase
         send_key(k);
         rnd_sent++;
      end

      drain_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("ran %0d keys: %0d stored, %0d duplicates, %0d refused while full",
               keys_sent, tracker.n_ins, tracker.n_dup, tracker.n_full);
      $display("set ended at %0d of %0d entries, %0d result beats checked",
               tracker.count, SET_CAP, tracker.n_checked);
      if (tracker.errors == 0) begin
         $display("tb_sorted_set_insert_if_absent: clean");
      end else begin
         $display("tb_sorted_set_insert_if_absent: errors");
      end
      $finish;
   end

   initial begin
      #50_000_000;
      $display("timeout with %0d results outstanding", tracker.pending.size());
      $display("tb_sorted_set_insert_if_absent: errors");
      $finish;
   end

endmodule
